FILE: src/ippfp_pkg.sv
// Shared types, codes and elaboration-time helpers for the I2C page programming frame parser.
`default_nettype none

package ippfp_pkg;

	// Default page size in bytes and reset value of the boot limit register.
	localparam int unsigned PageBytesDefault = 64;
	localparam logic [14:0] BootLimitReset   = 15'h1E00;

	// Frame parser phases.
	typedef enum logic [2:0] {
		PH_ADDR = 3'd0,
		PH_HIGH = 3'd1,
		PH_LOW  = 3'd2,
		PH_DATA = 3'd3,
		PH_STOP = 3'd4
	} phase_t;

	// Bus event kinds.
	typedef enum logic [1:0] {
		EV_SLA   = 2'd0,
		EV_DATA  = 2'd1,
		EV_STOP  = 2'd2,
		EV_OTHER = 2'd3
	} event_t;

	// Result action codes.
	typedef enum logic [2:0] {
		ACT_NONE        = 3'd0,
		ACT_FLASH_WORD  = 3'd1,
		ACT_EEPROM_WORD = 3'd2,
		ACT_COMMIT      = 3'd3,
		ACT_ERROR       = 3'd4
	} action_t;

	// One result transaction.
	typedef struct packed {
		action_t     action;
		logic [14:0] target_address;
		logic [15:0] data_word;
	} result_t;

	// Number of trailing zero bits of a non-zero constant.
	function automatic int unsigned trailing_zeros(input int unsigned value);
		int unsigned v;
		int unsigned n;
		v = value;
		n = 0;
		for (int i = 0; i < 31; i++) begin
			if ((v != 0) && ((v & 1) == 0)) begin
				v = v >> 1;
				n = n + 1;
			end
		end
		return n;
	endfunction

	// Multiplicative inverse of an odd constant modulo 2^15 (Newton iteration).
	function automatic int unsigned inverse_mod15(input int unsigned odd_value);
		int unsigned x;
		x = odd_value;
		for (int i = 0; i < 5; i++) begin
			x = (x * (32'd2 - odd_value * x)) & 32'h7FFF;
		end
		return x;
	endfunction

endpackage

`default_nettype wire

FILE: src/i2c_page_program_frame_parser_unit.sv
// Top level of the I2C page programming frame parser.
// Each event passes through the input register and then the result register; while the
// result register is full and not being emptied, the event waits in the input register.
// Throughput: one event per cycle; the result register, when stalled, is the only hold-up.
// Alignment uses a low-bit mask, a truncated multiply by a constant inverse and a compare.
// Reset clears the phase, the frame state, the sticky error and both valid flags at once;
// the boot limit returns to its reset value. There is no clearing pass.
`default_nettype none

module i2c_page_program_frame_parser_unit #(
	parameter int unsigned PAGE_BYTES = ippfp_pkg::PageBytesDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Event channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic [7:0]  rx_byte,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       action,
	output logic [14:0]      target_address,
	output logic [15:0]      data_word,
	// Configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [14:0] cfg_wr_data
);

	// Constants for the divisibility test: PAGE_BYTES = odd part * 2^PgTz.
	localparam int unsigned CntW    = $clog2(PAGE_BYTES + 1);
	localparam int unsigned PgTz    = ippfp_pkg::trailing_zeros(PAGE_BYTES);
	localparam int unsigned PgOdd   = PAGE_BYTES >> PgTz;
	localparam int unsigned PgInv   = ippfp_pkg::inverse_mod15(PgOdd);
	localparam int unsigned RemBits = 15 - PgTz;
	localparam int unsigned PgLim   = ((1 << RemBits) - 1) / PgOdd;
	localparam logic [14:0] LowMask = 15'((1 << PgTz) - 1);

	// Input stage
	logic                   valid_s1;
	logic [1:0]             func_s1;
	logic [7:0]             rx_byte_s1;
	logic                   advance;

	// Parser state
	ippfp_pkg::phase_t      phase_q, phase_nx;
	logic [14:0]            page_base_q, page_base_nx;
	logic [14:0]            write_ptr_q, write_ptr_nx;
	logic [CntW-1:0]        byte_count_q, byte_count_nx;
	logic [7:0]             low_byte_q, low_byte_nx;
	logic [7:0]             high_addr_q, high_addr_nx;
	logic                   eeprom_q, eeprom_nx;
	logic                   error_lock_q, error_lock_nx;
	logic [14:0]            boot_limit_q;

	// Result stage
	ippfp_pkg::result_t     res_nx, res_q;
	logic                   out_valid_q;

	// Alignment and limit checks on the received page address
	logic [15:0]            full_addr;
	logic [14:0]            page_addr;
	logic [14:0]            addr_shifted;
	logic [29:0]            addr_prod;
	logic                   aligned;
	logic [CntW-1:0]        count_inc;

	// The input register moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1    <= func;
			rx_byte_s1 <= rx_byte;
		end
	end

	// Boot limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_limit_q <= ippfp_pkg::BootLimitReset;
		end else if (cfg_wr_en) begin
			boot_limit_q <= cfg_wr_data;
		end
	end

	// Page address divisibility: the low bits must be zero and the rest times the odd
	// part's inverse must land in the range that multiples of the odd part map to.
	assign full_addr    = {high_addr_q, rx_byte_s1};
	assign page_addr    = full_addr[14:0];
	assign addr_shifted = page_addr >> PgTz;
	assign addr_prod    = addr_shifted * 15'(PgInv);
	assign aligned      = ((page_addr & LowMask) == 15'd0)
		&& (addr_prod[RemBits-1:0] <= RemBits'(PgLim));
	assign count_inc    = byte_count_q + CntW'(1);

	// Next state and result for the event in the input register.
	always_comb begin
		phase_nx      = phase_q;
		page_base_nx  = page_base_q;
		write_ptr_nx  = write_ptr_q;
		byte_count_nx = byte_count_q;
		low_byte_nx   = low_byte_q;
		high_addr_nx  = high_addr_q;
		eeprom_nx     = eeprom_q;
		error_lock_nx = error_lock_q;
		res_nx        = '{action: ippfp_pkg::ACT_NONE, target_address: '0, data_word: '0};

		if (error_lock_q) begin
			res_nx.action = ippfp_pkg::ACT_ERROR;
		end else begin
			unique case (phase_q)
				ippfp_pkg::PH_ADDR: begin
					if (func_s1 == ippfp_pkg::EV_SLA) begin
						phase_nx = ippfp_pkg::PH_HIGH;
					end else begin
						error_lock_nx = 1'b1;
					end
				end
				ippfp_pkg::PH_HIGH: begin
					if (func_s1 == ippfp_pkg::EV_DATA) begin
						high_addr_nx = rx_byte_s1;
						phase_nx     = ippfp_pkg::PH_LOW;
					end else begin
						error_lock_nx = 1'b1;
					end
				end
				ippfp_pkg::PH_LOW: begin
					if ((func_s1 != ippfp_pkg::EV_DATA) || !aligned
						|| (!full_addr[15] && (page_addr >= boot_limit_q))) begin
						error_lock_nx = 1'b1;
					end else begin
						eeprom_nx     = full_addr[15];
						page_base_nx  = page_addr;
						write_ptr_nx  = page_addr;
						byte_count_nx = '0;
						phase_nx      = ippfp_pkg::PH_DATA;
					end
				end
				ippfp_pkg::PH_DATA: begin
					if (func_s1 == ippfp_pkg::EV_DATA) begin
						byte_count_nx = count_inc;
						if (count_inc >= CntW'(PAGE_BYTES)) begin
							phase_nx = ippfp_pkg::PH_STOP;
						end
						if (!byte_count_q[0]) begin
							low_byte_nx = rx_byte_s1;
						end else begin
							// Second byte of a pair completes a word write.
							write_ptr_nx         = write_ptr_q + 15'd2;
							res_nx.action        = eeprom_q ? ippfp_pkg::ACT_EEPROM_WORD
								: ippfp_pkg::ACT_FLASH_WORD;
							res_nx.target_address = write_ptr_q;
							res_nx.data_word     = {rx_byte_s1, low_byte_q};
						end
					end else begin
						error_lock_nx = 1'b1;
					end
				end
				ippfp_pkg::PH_STOP: begin
					if (func_s1 == ippfp_pkg::EV_STOP) begin
						phase_nx = ippfp_pkg::PH_ADDR;
						if (!eeprom_q) begin
							res_nx.action         = ippfp_pkg::ACT_COMMIT;
							res_nx.target_address = page_base_q;
						end
					end else begin
						error_lock_nx = 1'b1;
					end
				end
				default: begin
					error_lock_nx = 1'b1;
				end
			endcase
			if (error_lock_nx) begin
				res_nx.action = ippfp_pkg::ACT_ERROR;
			end
		end
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ippfp_pkg::PH_ADDR;
			page_base_q  <= '0;
			write_ptr_q  <= '0;
			byte_count_q <= '0;
			low_byte_q   <= '0;
			high_addr_q  <= '0;
			eeprom_q     <= 1'b0;
			error_lock_q <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_nx;
			page_base_q  <= page_base_nx;
			write_ptr_q  <= write_ptr_nx;
			byte_count_q <= byte_count_nx;
			low_byte_q   <= low_byte_nx;
			high_addr_q  <= high_addr_nx;
			eeprom_q     <= eeprom_nx;
			error_lock_q <= error_lock_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = res_q.action;
	assign target_address = res_q.target_address;
	assign data_word      = res_q.data_word;

endmodule

`default_nettype wire

FILE: src/ippfp_checker.sv
// Port-level checker for the I2C page programming frame parser, bound to the top level.
`default_nettype none

module ippfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  action,
	input wire logic [14:0] target_address,
	input wire logic [15:0] data_word
);

	// Remembers that an error result has been delivered.
	logic err_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && out_ready && (action == ippfp_pkg::ACT_ERROR)) begin
			err_seen_q <= 1'b1;
		end
	end

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action)
			&& $stable(target_address) && $stable(data_word))
		else $error("result changed while stalled");

	// Once an error has been delivered, every later result is an error.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_seen_q && out_valid |-> action == ippfp_pkg::ACT_ERROR)
		else $error("result other than error after lock");

	// Only defined action codes appear.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= ippfp_pkg::ACT_ERROR)
		else $error("undefined action code");

	// Results without an address or word carry zeros there.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ippfp_pkg::ACT_NONE || action == ippfp_pkg::ACT_ERROR
			|| action == ippfp_pkg::ACT_COMMIT)
		|-> data_word == 16'd0
			&& (action == ippfp_pkg::ACT_COMMIT || target_address == 15'd0))
		else $error("stray address or data on a result");

endmodule

bind i2c_page_program_frame_parser_unit ippfp_checker u_ippfp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.action         (action),
	.target_address (target_address),
	.data_word      (data_word)
);

`default_nettype wire

FILE: bench/ippfp_result_checker.sv
// Checker that predicts and compares every result of the I2C page programming frame parser.
`timescale 1ns / 100ps

module ippfp_result_checker #(
	parameter int unsigned PAGE_BYTES = ippfp_pkg::PageBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  action,
	input  logic [14:0] target_address,
	input  logic [15:0] data_word,
	input  logic        cfg_wr_en,
	input  logic [14:0] cfg_wr_data,
	output int          mismatch_count,
	output int          awaited_results
);

	// Own copy of the parser state and of the boot limit register.
	logic [14:0]       boot_limit;
	ippfp_pkg::phase_t frame_phase;
	logic [14:0]       page_base;
	logic [14:0]       write_ptr;
	logic [8:0]        bytes_taken;
	logic [7:0]        low_byte;
	logic [7:0]        high_addr_byte;
	logic              eeprom_sel;
	logic              locked;

	// Results predicted but not yet seen on the result channel, oldest first.
	ippfp_pkg::result_t awaited_q[$];

	// Advances the parser by one bus event and works out the result it answers with.
	task automatic parse_event(input ippfp_pkg::event_t ev, input logic [7:0] b,
			output ippfp_pkg::result_t r);
		logic [15:0] full;
		logic [14:0] addr;
		r.action = ippfp_pkg::ACT_NONE;
		r.target_address = 15'd0;
		r.data_word = 16'd0;
		if (!locked) begin
			case (frame_phase)
				ippfp_pkg::PH_ADDR: begin
					if (ev == ippfp_pkg::EV_SLA)
						frame_phase = ippfp_pkg::PH_HIGH;
					else
						locked = 1'b1;
				end
				ippfp_pkg::PH_HIGH: begin
					if (ev == ippfp_pkg::EV_DATA) begin
						high_addr_byte = b;
						frame_phase = ippfp_pkg::PH_LOW;
					end else begin
						locked = 1'b1;
					end
				end
				ippfp_pkg::PH_LOW: begin
					full = {high_addr_byte, b};
					addr = full[14:0];
					// Alignment is judged without the EEPROM select bit; only flash pages meet the limit.
					if ((ev != ippfp_pkg::EV_DATA) || ((addr % PAGE_BYTES) != 0) ||
							(!full[15] && (addr >= boot_limit))) begin
						locked = 1'b1;
					end else begin
						eeprom_sel = full[15];
						page_base = addr;
						write_ptr = addr;
						bytes_taken = 9'd0;
						frame_phase = ippfp_pkg::PH_DATA;
					end
				end
				ippfp_pkg::PH_DATA: begin
					if (ev != ippfp_pkg::EV_DATA) begin
						locked = 1'b1;
					end else begin
						bytes_taken = bytes_taken + 9'd1;
						if (bytes_taken >= PAGE_BYTES)
							frame_phase = ippfp_pkg::PH_STOP;
						// An even count after the byte means it completes a little-endian word.
						if (!bytes_taken[0]) begin
							r.action = eeprom_sel ? ippfp_pkg::ACT_EEPROM_WORD
								: ippfp_pkg::ACT_FLASH_WORD;
							r.target_address = write_ptr;
							r.data_word = {b, low_byte};
							write_ptr = write_ptr + 15'd2;
						end else begin
							low_byte = b;
						end
					end
				end
				ippfp_pkg::PH_STOP: begin
					if (ev != ippfp_pkg::EV_STOP) begin
						locked = 1'b1;
					end else begin
						frame_phase = ippfp_pkg::PH_ADDR;
						if (!eeprom_sel) begin
							r.action = ippfp_pkg::ACT_COMMIT;
							r.target_address = page_base;
						end
					end
				end
				default: locked = 1'b1;
			endcase
		end
		if (locked) begin
			r.action = ippfp_pkg::ACT_ERROR;
			r.target_address = 15'd0;
			r.data_word = 16'd0;
		end
	endtask

	// Predict on each accepted event, compare each accepted result, follow register writes.
	always @(posedge clk or negedge arst_n) begin : track
		ippfp_pkg::result_t predicted;
		if (!arst_n) begin
			boot_limit = ippfp_pkg::BootLimitReset;
			frame_phase = ippfp_pkg::PH_ADDR;
			page_base = 15'd0;
			write_ptr = 15'd0;
			bytes_taken = 9'd0;
			low_byte = 8'd0;
			high_addr_byte = 8'd0;
			eeprom_sel = 1'b0;
			locked = 1'b0;
			awaited_q.delete();
			awaited_results = 0;
			mismatch_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				parse_event(ippfp_pkg::event_t'(func), rx_byte, predicted);
				awaited_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (awaited_q.size() == 0) begin
					$error("unexpected result transaction: action %0d, address %0h, word %0h",
						action, target_address, data_word);
					mismatch_count++;
				end else begin
					predicted = awaited_q.pop_front();
					if (action !== predicted.action) begin
						$error("action: expected %0d, actual %0d", predicted.action, action);
						mismatch_count++;
					end
					if (target_address !== predicted.target_address) begin
						$error("target_address: expected %0h, actual %0h",
							predicted.target_address, target_address);
						mismatch_count++;
					end
					if (data_word !== predicted.data_word) begin
						$error("data_word: expected %0h, actual %0h",
							predicted.data_word, data_word);
						mismatch_count++;
					end
				end
			end
			if (cfg_wr_en)
				boot_limit = cfg_wr_data;
			awaited_results = awaited_q.size();
		end
	end

endmodule

FILE: bench/i2c_page_program_frame_parser_unit_tb.sv
// Testbench top: drives frames and faults into the frame parser and gives the verdict.
`timescale 1ns / 100ps

module i2c_page_program_frame_parser_unit_tb;

	localparam int unsigned PageBytes    = ippfp_pkg::PageBytesDefault;
	localparam int unsigned TopPage      = 32768 - PageBytes;
	localparam int          RandomEvents = 130;
	localparam int          NoiseEvents  = 40;
	localparam int          StallLimit   = 1000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  func;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  action;
	logic [14:0] target_address;
	logic [15:0] data_word;
	logic        cfg_wr_en;
	logic [14:0] cfg_wr_data;

	int          mismatch_count;
	int          awaited_results;
	int          events_sent;
	int          frame_total;
	int          eeprom_frames;
	int          setting_total;
	int          quiet_cycles;
	logic [14:0] limit_now;
	logic        calm;

	i2c_page_program_frame_parser_unit #(
		.PAGE_BYTES(PageBytes)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.target_address(target_address),
		.data_word     (data_word),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	ippfp_result_checker #(
		.PAGE_BYTES(PageBytes)
	) u_result_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.action         (action),
		.target_address (target_address),
		.data_word      (data_word),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mismatch_count (mismatch_count),
		.awaited_results(awaited_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A window of the run in which neither side inserts random stalls.
	assign calm = (events_sent >= 400) && (events_sent < 560);

	// Outside the calm window, the result side stalls about six percent of the time.
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 6);
	end

	// Ends the run if nothing moves on either channel for too long.
	initial begin : watchdog
		quiet_cycles = 0;
		while (quiet_cycles < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[i2c_page_program_frame_parser_unit] ERROR");
		$finish;
	end

	// Offers one bus event and returns at the falling edge after its transaction.
	task automatic send_event(input ippfp_pkg::event_t ev, input logic [7:0] b);
		while (!calm && ($urandom_range(99) < 6)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= ev;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		events_sent++;
	endtask

	// Writes the boot limit once every predicted result has come back.
	task automatic write_boot_limit(input logic [14:0] value);
		in_valid <= 1'b0;
		while (awaited_results != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_now = value;
		setting_total++;
	endtask

	// Sends one page frame; at step cut_at a wrong event kind goes out instead and the frame ends.
	// Fill: 0 random, 1 all zero, 2 all ones, 3 alternating zero and ones.
	task automatic run_frame(input logic [15:0] full_addr, input int unsigned fill, input int cut_at);
		ippfp_pkg::event_t want;
		ippfp_pkg::event_t sent;
		logic [7:0]        b;
		for (int s = 0; s <= int'(PageBytes) + 3; s++) begin
			if (s == 0)
				want = ippfp_pkg::EV_SLA;
			else if (s == int'(PageBytes) + 3)
				want = ippfp_pkg::EV_STOP;
			else
				want = ippfp_pkg::EV_DATA;
			case (s)
				1: b = full_addr[15:8];
				2: b = full_addr[7:0];
				default: begin
					case (fill)
						0: b = 8'($urandom);
						1: b = 8'h00;
						2: b = 8'hFF;
						default: b = s[0] ? 8'hFF : 8'h00;
					endcase
				end
			endcase
			if (s == cut_at) begin
				sent = want;
				while (sent == want)
					sent = ippfp_pkg::event_t'($urandom_range(3));
				send_event(sent, 8'($urandom));
				return;
			end
			send_event(want, b);
		end
		frame_total++;
		if (full_addr[15])
			eeprom_frames++;
	endtask

	// Stimulus: directed frames, random frames over several limits, then one fault and noise.
	initial begin : stimulus
		int unsigned lower_pages;
		int unsigned page;
		int          frames_in_setting;
		int          directed_end;
		int unsigned fault_kind;
		logic        use_eeprom;
		logic [15:0] frame_addr;
		string       fault_name;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = ippfp_pkg::EV_SLA;
		rx_byte = 8'd0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 15'd0;
		events_sent = 0;
		frame_total = 0;
		eeprom_frames = 0;
		setting_total = 1;
		limit_now = ippfp_pkg::BootLimitReset;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset limit: lowest flash page, top EEPROM page, last flash page.
		run_frame(16'h0000, 2, -1);
		run_frame({1'b1, 15'(TopPage)}, 1, -1);
		run_frame({1'b0, ippfp_pkg::BootLimitReset - 15'(PageBytes)}, 3, -1);
		// A zero limit leaves only EEPROM; the largest limit admits the top flash page.
		write_boot_limit(15'd0);
		run_frame(16'h8000, 0, -1);
		write_boot_limit(15'h7FFF);
		run_frame({1'b0, 15'(TopPage)}, 0, -1);
		directed_end = events_sent;

		// Random well-formed frames, with a fresh random limit before each frame after the first.
		frames_in_setting = 0;
		while (events_sent < directed_end + RandomEvents) begin
			if (frames_in_setting == 1) begin
				write_boot_limit(15'($urandom_range(32767)));
				frames_in_setting = 0;
			end
			lower_pages = (32'(limit_now) + PageBytes - 1) / PageBytes;
			use_eeprom = (lower_pages == 0) || ($urandom_range(99) < 30);
			if (use_eeprom)
				frame_addr = {1'b1, 15'($urandom_range(32768 / PageBytes - 1) * PageBytes)};
			else
				frame_addr = {1'b0, 15'($urandom_range(lower_pages - 1) * PageBytes)};
			run_frame(frame_addr, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0, -1);
			frames_in_setting++;
		end

		// One fault locks the parser for the rest of the run.
		fault_kind = $urandom_range(2);
		page = $urandom_range(32768 / PageBytes - 1);
		case (fault_kind)
			0: begin
				fault_name = "unexpected event";
				run_frame({1'b1, 15'(page * PageBytes)}, 0, $urandom_range(PageBytes + 3));
			end
			1: begin
				fault_name = "misaligned page address";
				frame_addr = {1'($urandom), 15'(page * PageBytes + $urandom_range(1, PageBytes - 1))};
				run_frame(frame_addr, 0, 3);
			end
			default: begin
				fault_name = "flash page at the boot limit";
				write_boot_limit(15'(page * PageBytes));
				run_frame({1'b0, limit_now}, 0, 3);
			end
		endcase
		send_event(ippfp_pkg::EV_OTHER, 8'($urandom));
		repeat (NoiseEvents - 1)
			send_event(ippfp_pkg::event_t'($urandom_range(3)), 8'($urandom));
		in_valid <= 1'b0;

		// Drain, then wait for any stray result before the verdict.
		while (awaited_results != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d events in %0d complete frames (%0d to EEPROM) under %0d boot limit values.",
			events_sent, frame_total, eeprom_frames, setting_total);
		$display("Closing fault: %s, then %0d events into the locked parser.",
			fault_name, NoiseEvents);
		if (mismatch_count == 0)
			$display("[i2c_page_program_frame_parser_unit] OK");
		else
			$display("[i2c_page_program_frame_parser_unit] ERROR");
		$finish;
	end

endmodule
